[design/slr_pkg.sv]
package slr_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int DIFF_W      = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int DOT_W       = DIFF_W + 18;
    localparam int ROOT_W      = 32;
    localparam int COS_QW      = 17;
    localparam int NUM_W       = 41;
    localparam int OUT_QW      = 16;
    localparam int ADDR_W      = 6;

    localparam logic [16:0] FACTOR_ONE = 17'h10000;

    typedef enum logic [2:0] {
        REG_POS_X = 3'd0,
        REG_POS_Y = 3'd1,
        REG_POS_Z = 3'd2,
        REG_DIR   = 3'd3,
        REG_INT   = 3'd4,
        REG_ATT   = 3'd5,
        REG_CONE  = 3'd6,
        REG_ICR   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [47:0]        dir;
        logic [47:0]        intensity;
        logic [47:0]        att;
        logic [31:0]        cone;
        logic [23:0]        icr;
    } cfg_t;

endpackage

[design/slr_regs.sv]
module slr_regs
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [slr_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready,
    output slr_pkg::cfg_t              cfg
);
    import slr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            unique case (idx)
                REG_POS_X: cfg_next.pos_x     = pwdata[31:0];
                REG_POS_Y: cfg_next.pos_y     = pwdata[31:0];
                REG_POS_Z: cfg_next.pos_z     = pwdata[31:0];
                REG_DIR:   cfg_next.dir       = pwdata[47:0];
                REG_INT:   cfg_next.intensity = pwdata[47:0];
                REG_ATT:   cfg_next.att       = pwdata[47:0];
                REG_CONE:  cfg_next.cone      = pwdata[31:0];
                REG_ICR:   cfg_next.icr       = pwdata[23:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{pos_x: '0, pos_y: '0, pos_z: '0, dir: '0, intensity: '0,
                         att: 48'd256, cone: '0, icr: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_POS_X: prdata = {32'b0, cfg_reg.pos_x};
            REG_POS_Y: prdata = {32'b0, cfg_reg.pos_y};
            REG_POS_Z: prdata = {32'b0, cfg_reg.pos_z};
            REG_DIR:   prdata = {16'b0, cfg_reg.dir};
            REG_INT:   prdata = {16'b0, cfg_reg.intensity};
            REG_ATT:   prdata = {16'b0, cfg_reg.att};
            REG_CONE:  prdata = {32'b0, cfg_reg.cone};
            REG_ICR:   prdata = {40'b0, cfg_reg.icr};
        endcase
    end

endmodule

[design/slr_front.sv]
module slr_front
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [31:0]               point_x,
    input  logic signed [31:0]               point_y,
    input  logic signed [31:0]               point_z,
    input  slr_pkg::cfg_t                    cfg,
    output logic                             out_valid,
    output logic [63:0]                      dsq,
    output logic signed [slr_pkg::DOT_W-1:0] dot
);
    import slr_pkg::*;

    localparam logic signed [32:0] DIFF_HI = 33'((64'sd1 <<< (DIFF_W - 1)) - 64'sd1);
    localparam logic signed [32:0] DIFF_LO = -DIFF_HI - 33'sd1;

    logic signed [31:0]        pt [3];
    logic signed [31:0]        pos [3];
    logic signed [32:0]        raw [3];
    logic signed [DIFF_W-1:0]  diff_next [3];
    logic signed [DIFF_W-1:0]  diff_reg [3];
    logic [DIFF_W-1:0]         mag [3];
    logic [2*DIFF_W-1:0]       sqw [3];
    logic [63:0]               sq_next [3];
    logic [63:0]               sq_reg [3];
    logic signed [DIFF_W+15:0] pr_next [3];
    logic signed [DIFF_W+15:0] pr_reg [3];
    logic [63:0]               dsq_next;
    logic [63:0]               dsq_reg;
    logic signed [DOT_W-1:0]   dot_next;
    logic signed [DOT_W-1:0]   dot_reg;
    logic                      v1_reg;
    logic                      v2_reg;
    logic                      v3_reg;

    assign pt[0]  = point_x;
    assign pt[1]  = point_y;
    assign pt[2]  = point_z;
    assign pos[0] = cfg.pos_x;
    assign pos[1] = cfg.pos_y;
    assign pos[2] = cfg.pos_z;

    always_comb
    begin
        dsq_next = '0;
        dot_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            raw[k] = $signed({pt[k][31], pt[k]}) - $signed({pos[k][31], pos[k]});
            if (raw[k] > DIFF_HI)
                diff_next[k] = DIFF_HI[DIFF_W-1:0];
            else if (raw[k] < DIFF_LO)
                diff_next[k] = DIFF_LO[DIFF_W-1:0];
            else
                diff_next[k] = raw[k][DIFF_W-1:0];

            mag[k]     = diff_reg[k][DIFF_W-1] ? DIFF_W'(-diff_reg[k]) : diff_reg[k];
            sqw[k]     = mag[k] * mag[k];
            sq_next[k] = 64'(sqw[k]);
            pr_next[k] = $signed(cfg.dir[16*k +: 16]) * diff_reg[k];

            dsq_next = dsq_next + sq_reg[k];
            dot_next = dot_next + DOT_W'(pr_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
        sq_reg   <= sq_next;
        pr_reg   <= pr_next;
        dsq_reg  <= dsq_next;
        dot_reg  <= dot_next;
    end

    assign out_valid = v3_reg;
    assign dsq       = dsq_reg;
    assign dot       = dot_reg;

endmodule

[design/slr_sqrt.sv]
module slr_sqrt
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [63:0]                      in_dsq,
    input  logic signed [slr_pkg::DOT_W-1:0] in_dot,
    output logic                             out_valid,
    output logic [slr_pkg::ROOT_W-1:0]       root,
    output logic [63:0]                      out_dsq,
    output logic signed [slr_pkg::DOT_W-1:0] out_dot
);
    import slr_pkg::*;

    logic                    vld_reg  [ROOT_W];
    logic                    vld_next [ROOT_W];
    logic [63:0]             rem_reg  [ROOT_W];
    logic [63:0]             rem_next [ROOT_W];
    logic [ROOT_W-1:0]       root_reg  [ROOT_W];
    logic [ROOT_W-1:0]       root_next [ROOT_W];
    logic [63:0]             dsq_reg  [ROOT_W];
    logic [63:0]             dsq_next [ROOT_W];
    logic signed [DOT_W-1:0] dot_reg  [ROOT_W];
    logic signed [DOT_W-1:0] dot_next [ROOT_W];

    always_comb
    begin
        logic                    s_vld;
        logic [63:0]             s_rem;
        logic [ROOT_W-1:0]       s_root;
        logic [63:0]             s_dsq;
        logic signed [DOT_W-1:0] s_dot;
        logic [65:0]             trial;
        int                      k;
        for (int s = 0; s < ROOT_W; s++)
        begin
            if (s == 0)
            begin
                s_vld  = in_valid;
                s_rem  = in_dsq;
                s_root = '0;
                s_dsq  = in_dsq;
                s_dot  = in_dot;
            end
            else
            begin
                s_vld  = vld_reg[s-1];
                s_rem  = rem_reg[s-1];
                s_root = root_reg[s-1];
                s_dsq  = dsq_reg[s-1];
                s_dot  = dot_reg[s-1];
            end
            k     = ROOT_W - 1 - s;
            trial = (66'(s_root) << (k + 1)) | (66'd1 << (2 * k));
            if (66'(s_rem) >= trial)
            begin
                rem_next[s]  = s_rem - trial[63:0];
                root_next[s] = s_root | (ROOT_W'(1) << k);
            end
            else
            begin
                rem_next[s]  = s_rem;
                root_next[s] = s_root;
            end
            vld_next[s] = s_vld;
            dsq_next[s] = s_dsq;
            dot_next[s] = s_dot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < ROOT_W; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        dsq_reg  <= dsq_next;
        dot_reg  <= dot_next;
    end

    assign out_valid = vld_reg[ROOT_W-1];
    assign root      = root_reg[ROOT_W-1];
    assign out_dsq   = dsq_reg[ROOT_W-1];
    assign out_dot   = dot_reg[ROOT_W-1];

endmodule

[design/slr_cone.sv]
module slr_cone
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic [slr_pkg::ROOT_W-1:0]       distance,
    input  logic [63:0]                      dsq,
    input  logic signed [slr_pkg::DOT_W-1:0] dot,
    input  slr_pkg::cfg_t                    cfg,
    output logic                             out_valid,
    output logic [16:0]                      factor,
    output logic [63:0]                      den,
    output logic                             unlit
);
    import slr_pkg::*;

    logic               a_vld_reg;
    logic               a_neg_reg;
    logic [DOT_W-1:0]   a_mag_reg;
    logic [DOT_W-1:0]   a_mag_next;
    logic [ROOT_W-1:0]  a_d_reg;
    logic               a_zero_reg;
    logic [47:0]        a_lin_reg;
    logic [47:0]        a_lin_next;
    logic [63:0]        a_quad_reg;
    logic [63:0]        a_quad_next;
    logic [DOT_W-1:0]   dot_u;

    logic               q_vld_reg  [COS_QW];
    logic               q_vld_next [COS_QW];
    logic [DOT_W-1:0]   q_rem_reg  [COS_QW];
    logic [DOT_W-1:0]   q_rem_next [COS_QW];
    logic [COS_QW-1:0]  q_quo_reg  [COS_QW];
    logic [COS_QW-1:0]  q_quo_next [COS_QW];
    logic               q_neg_reg  [COS_QW];
    logic               q_neg_next [COS_QW];
    logic [ROOT_W-1:0]  q_d_reg    [COS_QW];
    logic [ROOT_W-1:0]  q_d_next   [COS_QW];
    logic               q_zero_reg  [COS_QW];
    logic               q_zero_next [COS_QW];
    logic [63:0]        q_den_reg  [COS_QW];
    logic [63:0]        q_den_next [COS_QW];
    logic [63:0]        den_sum;

    logic               c_vld_reg;
    logic signed [COS_QW:0] c_cos_reg;
    logic signed [COS_QW:0] c_cos_next;
    logic               c_zero_reg;
    logic [63:0]        c_den_reg;

    logic signed [COS_QW+1:0] m_diff;
    logic               m_vld_reg;
    logic [41:0]        m_prod_reg;
    logic [41:0]        m_prod_next;
    logic               m_le_reg;
    logic               m_ge_reg;
    logic               m_zero_reg;
    logic [63:0]        m_den_reg;

    logic               f_vld_reg;
    logic [16:0]        f_factor_reg;
    logic [16:0]        f_factor_next;
    logic [31:0]        f_scaled;
    logic [63:0]        f_den_reg;
    logic               f_unlit_reg;

    logic signed [15:0] inner;
    logic signed [15:0] outer;

    assign inner = cfg.cone[15:0];
    assign outer = cfg.cone[31:16];

    assign dot_u       = dot;
    assign a_mag_next  = dot[DOT_W-1] ? (~dot_u + DOT_W'(1)) : dot_u;
    assign a_lin_next  = cfg.att[31:16] * distance;
    assign a_quad_next = cfg.att[47:32] * dsq[63:16];

    always_comb
    begin
        den_sum = (64'(cfg.att[15:0]) << 16) + 64'(a_lin_reg) + a_quad_reg;
        if (den_sum == 64'd0)
            den_sum = 64'd1;
    end

    always_comb
    begin
        logic              s_vld;
        logic [DOT_W-1:0]  s_rem;
        logic [COS_QW-1:0] s_quo;
        logic              s_neg;
        logic [ROOT_W-1:0] s_d;
        logic              s_zero;
        logic [63:0]       s_den;
        logic              take;
        int                i;
        for (int s = 0; s < COS_QW; s++)
        begin
            if (s == 0)
            begin
                s_vld  = a_vld_reg;
                s_rem  = a_mag_reg;
                s_quo  = '0;
                s_neg  = a_neg_reg;
                s_d    = a_d_reg;
                s_zero = a_zero_reg;
                s_den  = den_sum;
            end
            else
            begin
                s_vld  = q_vld_reg[s-1];
                s_rem  = q_rem_reg[s-1];
                s_quo  = q_quo_reg[s-1];
                s_neg  = q_neg_reg[s-1];
                s_d    = q_d_reg[s-1];
                s_zero = q_zero_reg[s-1];
                s_den  = q_den_reg[s-1];
            end
            i    = COS_QW - 1 - s;
            take = (s_rem >> i) >= DOT_W'(s_d);
            if (take)
            begin
                q_rem_next[s] = s_rem - (DOT_W'(s_d) << i);
                q_quo_next[s] = s_quo | (COS_QW'(1) << i);
            end
            else
            begin
                q_rem_next[s] = s_rem;
                q_quo_next[s] = s_quo;
            end
            q_vld_next[s]  = s_vld;
            q_neg_next[s]  = s_neg;
            q_d_next[s]    = s_d;
            q_zero_next[s] = s_zero;
            q_den_next[s]  = s_den;
        end
    end

    assign c_cos_next = q_neg_reg[COS_QW-1] ? -$signed({1'b0, q_quo_reg[COS_QW-1]})
                                            : $signed({1'b0, q_quo_reg[COS_QW-1]});

    assign m_diff      = $signed({c_cos_reg[COS_QW], c_cos_reg})
                       - $signed({{(COS_QW-14){outer[15]}}, outer});
    assign m_prod_next = m_diff[COS_QW:0] * cfg.icr;

    always_comb
    begin
        f_scaled = m_prod_reg[41:10];
        if (inner == outer)
            f_factor_next = m_ge_reg ? FACTOR_ONE : 17'd0;
        else if (m_le_reg)
            f_factor_next = 17'd0;
        else if (f_scaled > 32'(FACTOR_ONE))
            f_factor_next = FACTOR_ONE;
        else
            f_factor_next = f_scaled[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            for (int s = 0; s < COS_QW; s++)
            begin
                q_vld_reg[s] <= 1'b0;
            end
            c_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_valid;
            q_vld_reg <= q_vld_next;
            c_vld_reg <= q_vld_reg[COS_QW-1];
            m_vld_reg <= c_vld_reg;
            f_vld_reg <= m_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_neg_reg    <= dot[DOT_W-1];
        a_mag_reg    <= a_mag_next;
        a_d_reg      <= distance;
        a_zero_reg   <= (dsq == 64'd0);
        a_lin_reg    <= a_lin_next;
        a_quad_reg   <= a_quad_next;

        q_rem_reg    <= q_rem_next;
        q_quo_reg    <= q_quo_next;
        q_neg_reg    <= q_neg_next;
        q_d_reg      <= q_d_next;
        q_zero_reg   <= q_zero_next;
        q_den_reg    <= q_den_next;

        c_cos_reg    <= c_cos_next;
        c_zero_reg   <= q_zero_reg[COS_QW-1];
        c_den_reg    <= q_den_reg[COS_QW-1];

        m_prod_reg   <= m_prod_next;
        m_le_reg     <= m_diff[COS_QW+1] | (m_diff == '0);
        m_ge_reg     <= ~m_diff[COS_QW+1];
        m_zero_reg   <= c_zero_reg;
        m_den_reg    <= c_den_reg;

        f_factor_reg <= f_factor_next;
        f_den_reg    <= m_den_reg;
        f_unlit_reg  <= m_zero_reg | (f_factor_next == 17'd0);
    end

    assign out_valid = f_vld_reg;
    assign factor    = f_factor_reg;
    assign den       = f_den_reg;
    assign unlit     = f_unlit_reg;

endmodule

[design/slr_scale.sv]
module slr_scale
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [16:0]   factor,
    input  logic [63:0]   den,
    input  logic          in_unlit,
    input  slr_pkg::cfg_t cfg,
    output logic          out_valid,
    output logic [15:0]   radiance_r,
    output logic [15:0]   radiance_g,
    output logic [15:0]   radiance_b,
    output logic          unlit
);
    import slr_pkg::*;

    logic              m_vld_reg;
    logic [NUM_W-1:0]  m_num_reg  [3];
    logic [NUM_W-1:0]  m_num_next [3];
    logic [63:0]       m_den_reg;
    logic              m_unlit_reg;

    logic              d_vld_reg   [OUT_QW];
    logic              d_vld_next  [OUT_QW];
    logic [NUM_W-1:0]  d_rem_reg   [OUT_QW][3];
    logic [NUM_W-1:0]  d_rem_next  [OUT_QW][3];
    logic [OUT_QW-1:0] d_quo_reg   [OUT_QW][3];
    logic [OUT_QW-1:0] d_quo_next  [OUT_QW][3];
    logic              d_sat_reg   [OUT_QW][3];
    logic              d_sat_next  [OUT_QW][3];
    logic [63:0]       d_den_reg   [OUT_QW];
    logic [63:0]       d_den_next  [OUT_QW];
    logic              d_unlit_reg  [OUT_QW];
    logic              d_unlit_next [OUT_QW];

    logic              o_vld_reg;
    logic [15:0]       o_rad_reg  [3];
    logic [15:0]       o_rad_next [3];
    logic              o_unlit_reg;

    always_comb
    begin
        logic [32:0] p;
        for (int k = 0; k < 3; k++)
        begin
            p             = cfg.intensity[16*k +: 16] * factor;
            m_num_next[k] = {p, 8'b0};
        end
    end

    always_comb
    begin
        logic [NUM_W-1:0]  s_rem;
        logic [OUT_QW-1:0] s_quo;
        logic              s_sat;
        logic [63:0]       s_den;
        logic              take;
        int                i;
        for (int s = 0; s < OUT_QW; s++)
        begin
            s_den           = (s == 0) ? m_den_reg : d_den_reg[s-1];
            d_den_next[s]   = s_den;
            d_vld_next[s]   = (s == 0) ? m_vld_reg : d_vld_reg[s-1];
            d_unlit_next[s] = (s == 0) ? m_unlit_reg : d_unlit_reg[s-1];
            i               = OUT_QW - 1 - s;
            for (int k = 0; k < 3; k++)
            begin
                if (s == 0)
                begin
                    s_rem = m_num_reg[k];
                    s_quo = '0;
                    s_sat = 64'(m_num_reg[k] >> OUT_QW) >= s_den;
                end
                else
                begin
                    s_rem = d_rem_reg[s-1][k];
                    s_quo = d_quo_reg[s-1][k];
                    s_sat = d_sat_reg[s-1][k];
                end
                take = 64'(s_rem >> i) >= s_den;
                if (take)
                begin
                    d_rem_next[s][k] = s_rem - (s_den[NUM_W-1:0] << i);
                    d_quo_next[s][k] = s_quo | (OUT_QW'(1) << i);
                end
                else
                begin
                    d_rem_next[s][k] = s_rem;
                    d_quo_next[s][k] = s_quo;
                end
                d_sat_next[s][k] = s_sat;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            if (d_unlit_reg[OUT_QW-1])
                o_rad_next[k] = 16'd0;
            else if (d_sat_reg[OUT_QW-1][k])
                o_rad_next[k] = 16'hFFFF;
            else
                o_rad_next[k] = d_quo_reg[OUT_QW-1][k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
            for (int s = 0; s < OUT_QW; s++)
            begin
                d_vld_reg[s] <= 1'b0;
            end
            o_vld_reg <= 1'b0;
        end
        else
        begin
            m_vld_reg <= in_valid;
            d_vld_reg <= d_vld_next;
            o_vld_reg <= d_vld_reg[OUT_QW-1];
        end
    end

    always_ff @(posedge clk)
    begin
        m_num_reg   <= m_num_next;
        m_den_reg   <= den;
        m_unlit_reg <= in_unlit;
        d_rem_reg   <= d_rem_next;
        d_quo_reg   <= d_quo_next;
        d_sat_reg   <= d_sat_next;
        d_den_reg   <= d_den_next;
        d_unlit_reg <= d_unlit_next;
        o_rad_reg   <= o_rad_next;
        o_unlit_reg <= d_unlit_reg[OUT_QW-1];
    end

    assign out_valid  = o_vld_reg;
    assign radiance_r = o_rad_reg[0];
    assign radiance_g = o_rad_reg[1];
    assign radiance_b = o_rad_reg[2];
    assign unlit      = o_unlit_reg;

endmodule

[design/spot_light_radiance.sv]
// Spot light radiance, one sample point per clock. start is taken at every
// edge (busy is always low) and done pulses for one cycle per point, with
// the red, green and blue radiance, the unlit flag and the light position.
// The pipeline holds the 32-step square root, the 17-step cosine divider and
// the 16-step channel divider, one register stage per step. The receiver
// cannot stall the block: catch every beat in the cycle done is high.
// Registers are written through the APB port at 8-byte spacing; the user
// must write them only while no point is in flight: the block does not check.
module spot_light_radiance
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic signed [31:0]         point_x,
    input  logic signed [31:0]         point_y,
    input  logic signed [31:0]         point_z,
    output logic                       done,
    output logic [15:0]                radiance_r,
    output logic [15:0]                radiance_g,
    output logic [15:0]                radiance_b,
    output logic signed [31:0]         source_x,
    output logic signed [31:0]         source_y,
    output logic signed [31:0]         source_z,
    output logic                       unlit,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [slr_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    output logic [63:0]                prdata,
    output logic                       pready
);
    import slr_pkg::*;

    cfg_t                    cfg;
    logic                    fr_valid;
    logic [63:0]             fr_dsq;
    logic signed [DOT_W-1:0] fr_dot;
    logic                    sq_valid;
    logic [ROOT_W-1:0]       sq_root;
    logic [63:0]             sq_dsq;
    logic signed [DOT_W-1:0] sq_dot;
    logic                    cn_valid;
    logic [16:0]             cn_factor;
    logic [63:0]             cn_den;
    logic                    cn_unlit;

    assign busy = 1'b0;

    slr_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .cfg       (cfg),
        .out_valid (fr_valid),
        .dsq       (fr_dsq),
        .dot       (fr_dot)
    );

    slr_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_dsq    (fr_dsq),
        .in_dot    (fr_dot),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_dsq   (sq_dsq),
        .out_dot   (sq_dot)
    );

    slr_cone u_cone
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .distance  (sq_root),
        .dsq       (sq_dsq),
        .dot       (sq_dot),
        .cfg       (cfg),
        .out_valid (cn_valid),
        .factor    (cn_factor),
        .den       (cn_den),
        .unlit     (cn_unlit)
    );

    slr_scale u_scale
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cn_valid),
        .factor     (cn_factor),
        .den        (cn_den),
        .in_unlit   (cn_unlit),
        .cfg        (cfg),
        .out_valid  (done),
        .radiance_r (radiance_r),
        .radiance_g (radiance_g),
        .radiance_b (radiance_b),
        .unlit      (unlit)
    );

    assign source_x = cfg.pos_x;
    assign source_y = cfg.pos_y;
    assign source_z = cfg.pos_z;

endmodule

[verif/slr_checker.sv]
module slr_checker
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic                       busy,
    input  logic signed [31:0]         point_x,
    input  logic signed [31:0]         point_y,
    input  logic signed [31:0]         point_z,
    input  logic                       done,
    input  logic [15:0]                radiance_r,
    input  logic [15:0]                radiance_g,
    input  logic [15:0]                radiance_b,
    input  logic signed [31:0]         source_x,
    input  logic signed [31:0]         source_y,
    input  logic signed [31:0]         source_z,
    input  logic                       unlit,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [slr_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                pwdata,
    input  logic                       pready,
    output int                         errors,
    output int                         pending
);
    import slr_pkg::*;

    typedef longint unsigned u64_t;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic        dark;
    } shade_t;

    logic [63:0] light_regs [8];
    shade_t      shade_q [$];

    function automatic u64_t floor_root(input u64_t v);
        u64_t r;
        u64_t b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic shade_t shade_point(input logic signed [31:0] px,
                                           input logic signed [31:0] py,
                                           input logic signed [31:0] pz);
        logic signed [31:0] pt [3];
        logic signed [31:0] lp;
        logic signed [15:0] h;
        longint             diff [3];
        u64_t               a, dsq, d, fac, den, num, v;
        longint             dotp, cosv, inner, outer;
        shade_t             res;
        pt = '{px, py, pz};
        dsq = 0;
        dotp = 0;
        for (int k = 0; k < 3; k++)
        begin
            lp = light_regs[k][31:0];
            diff[k] = longint'(pt[k]) - longint'(lp);
            if (diff[k] > 64'sd2147483647)
                diff[k] = 64'sd2147483647;
            if (diff[k] < -64'sd2147483648)
                diff[k] = -64'sd2147483648;
            a = (diff[k] < 0) ? u64_t'(-diff[k]) : u64_t'(diff[k]);
            dsq += a * a;
        end
        res.sx = light_regs[REG_POS_X][31:0];
        res.sy = light_regs[REG_POS_Y][31:0];
        res.sz = light_regs[REG_POS_Z][31:0];
        res.r = 0;
        res.g = 0;
        res.b = 0;
        res.dark = 1'b1;
        if (dsq == 0)
            return res;
        d = floor_root(dsq);
        for (int k = 0; k < 3; k++)
        begin
            h = light_regs[REG_DIR][16*k +: 16];
            dotp += longint'(h) * diff[k];
        end
        cosv = dotp / longint'(d);
        h = light_regs[REG_CONE][15:0];
        inner = longint'(h);
        h = light_regs[REG_CONE][31:16];
        outer = longint'(h);
        if (inner == outer)
            fac = (cosv >= outer) ? 64'd65536 : 64'd0;
        else if (cosv <= outer)
            fac = 0;
        else
        begin
            fac = (u64_t'(cosv - outer) * light_regs[REG_ICR][23:0]) >> 10;
            if (fac > 64'd65536)
                fac = 64'd65536;
        end
        if (fac == 0)
            return res;
        den = (u64_t'(light_regs[REG_ATT][15:0]) << 16)
            + u64_t'(light_regs[REG_ATT][31:16]) * d
            + u64_t'(light_regs[REG_ATT][47:32]) * (dsq >> 16);
        if (den == 0)
            den = 1;
        for (int i = 0; i < 3; i++)
        begin
            num = u64_t'(light_regs[REG_INT][16*i +: 16]) * fac * 256;
            v = num / den;
            if (v > 64'hFFFF)
                v = 64'hFFFF;
            case (i)
                0: res.r = v[15:0];
                1: res.g = v[15:0];
                default: res.b = v[15:0];
            endcase
        end
        res.dark = 1'b0;
        return res;
    endfunction

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t: %s mismatch: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        shade_t want;
        reg_idx_t idx;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                light_regs[i] <= (i == int'(REG_ATT)) ? 64'd256 : 64'd0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                idx = reg_idx_t'(paddr[ADDR_W-1:3]);
                case (idx)
                    REG_DIR, REG_INT, REG_ATT: light_regs[idx] <= {16'd0, pwdata[47:0]};
                    REG_ICR: light_regs[idx] <= {40'd0, pwdata[23:0]};
                    default: light_regs[idx] <= {32'd0, pwdata[31:0]};
                endcase
            end
            if (start && !busy)
                shade_q.push_back(shade_point(point_x, point_y, point_z));
            if (done)
            begin
                if (shade_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected", $realtime);
                    errors++;
                end
                else
                begin
                    want = shade_q.pop_front();
                    if (radiance_r !== want.r) report("radiance_r", radiance_r, want.r);
                    if (radiance_g !== want.g) report("radiance_g", radiance_g, want.g);
                    if (radiance_b !== want.b) report("radiance_b", radiance_b, want.b);
                    if (source_x !== want.sx) report("source_x", source_x, want.sx);
                    if (source_y !== want.sy) report("source_y", source_y, want.sy);
                    if (source_z !== want.sz) report("source_z", source_z, want.sz);
                    if (unlit !== want.dark) report("unlit", unlit, want.dark);
                end
            end
        end
    end

    initial errors = 0;
    assign pending = shade_q.size();

endmodule

[verif/tb_spot_light_radiance.sv]
module tb_spot_light_radiance;
    import slr_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int ONE = 1 << 16;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               done;
    logic [15:0]        radiance_r;
    logic [15:0]        radiance_g;
    logic [15:0]        radiance_b;
    logic signed [31:0] source_x;
    logic signed [31:0] source_y;
    logic signed [31:0] source_z;
    logic               unlit;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;
    int                 errors;
    int                 pending;
    int                 quiet_cycles;
    logic               no_gaps;

    spot_light_radiance u_dut (.*);

    slr_checker u_chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .done(done), .radiance_r(radiance_r), .radiance_g(radiance_g),
        .radiance_b(radiance_b), .source_x(source_x), .source_y(source_y),
        .source_z(source_z), .unlit(unlit), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .pready(pready),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input reg_idx_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic load_light(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [47:0] dir,
                              input logic [47:0] inten, input logic [47:0] att,
                              input logic [31:0] cone, input logic [23:0] icr);
        drain();
        write_reg(REG_POS_X, 64'(px));
        write_reg(REG_POS_Y, 64'(py));
        write_reg(REG_POS_Z, 64'(pz));
        write_reg(REG_DIR, 64'(dir));
        write_reg(REG_INT, 64'(inten));
        write_reg(REG_ATT, 64'(att));
        write_reg(REG_CONE, 64'(cone));
        write_reg(REG_ICR, 64'(icr));
    endtask

    task automatic send_point(input logic [31:0] x, input logic [31:0] y,
                              input logic [31:0] z);
        start   <= 1'b1;
        point_x <= x;
        point_y <= y;
        point_z <= z;
        do
            @(posedge clk);
        while (busy);
        if (!no_gaps && $urandom_range(99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic logic [15:0] rand_cos();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    function automatic logic [31:0] near(input logic [31:0] base);
        return base + 32'($signed($urandom_range(8 * ONE)) - 4 * ONE);
    endfunction

    logic [31:0] dir_pts [8][3];
    logic [31:0] lx, ly, lz;
    logic [15:0] ci, co;

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        point_x = '0;
        point_y = '0;
        point_z = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        no_gaps = 1'b0;
        quiet_cycles = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        dir_pts = '{'{0, 0, 0}, '{0, 0, ONE}, '{ONE, 0, ONE}, '{0, 0, -ONE},
                    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
                    '{32'h80000000, 32'h80000000, 32'h80000000},
                    '{3 * ONE, 0, ONE}, '{0, 0, 200 * ONE}};
        for (int i = 0; i < 3; i++)
            send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);

        // hard edge, soft edge, then no constant term with a zero inverse range
        load_light(0, 0, 0, 48'h4000_0000_0000, 48'hFFFF_8000_0100,
                   48'h0001_0010_0100, 32'h2D41_2D41, 24'd0);
        for (int i = 0; i < 8; i++)
            send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);
        load_light(0, 0, 0, 48'h4000_0000_0000, 48'h0001_8000_0100,
                   48'h0040_0040_0100, 32'h2710_3A98, 24'd13421);
        for (int i = 0; i < 8; i++)
            send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);
        load_light(0, 0, 0, 48'h4000_0000_0000, 48'h0000_0001_0100,
                   48'h0000_0000_0000, 32'h2710_3A98, 24'd0);
        for (int i = 0; i < 4; i++)
            send_point(dir_pts[i][0], dir_pts[i][1], dir_pts[i][2]);
        load_light(0, 0, 0, 48'h4000_0000_0000, 48'h0000_0001_0100,
                   48'h0000_0000_0000, 32'h0000_0000, 24'd0);
        send_point(0, 0, ONE);

        for (int p = 0; p < 9; p++)
        begin
            no_gaps = (p == 3);
            if (p == 0)
                load_light(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '1, '1, '1, '1, '1);
            else if (p == 1)
                load_light(32'h80000000, 32'h80000000, 32'h80000000, '0, '0, '0, '0, '0);
            else
            begin
                lx = (p % 3 == 0) ? $urandom : near(0);
                ly = (p % 3 == 0) ? $urandom : near(0);
                lz = (p % 3 == 0) ? $urandom : near(0);
                ci = rand_cos();
                co = (p == 5) ? ci : rand_cos();
                if ($signed(ci) < $signed(co))
                    {ci, co} = {co, ci};
                load_light(lx, ly, lz,
                           {rand_cos(), rand_cos(), rand_cos()},
                           {16'($urandom), 16'($urandom), 16'($urandom)},
                           {16'($urandom_range(255)), 16'($urandom_range(1023)),
                            (p == 7) ? 16'd0 : 16'($urandom_range(1, 2000))},
                           {co, ci}, (p == 8) ? 24'($urandom) : 24'($urandom_range(1 << 16)));
            end
            for (int n = 0; n < 215; n++)
            begin
                if ($urandom_range(99) < 70)
                    send_point(near(source_x), near(source_y), near(source_z));
                else
                    send_point($urandom, $urandom, $urandom);
            end
        end

        no_gaps = 1'b0;
        drain();
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
